>>> hdl/rbf_poly_kernel_evaluator_top_assert.svh
// Assertion macros shared by the kernel evaluator RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef RBF_POLY_KERNEL_EVALUATOR_TOP_ASSERT_SVH
`define RBF_POLY_KERNEL_EVALUATOR_TOP_ASSERT_SVH

// condition must never hold at a clock edge
`define RPK_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");

// antecedent implies consequent at the next clock edge
`define RPK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/rpk_pkg.sv
// Shared types and constants of the RBF / polynomial kernel evaluator.
// No dependencies.
`default_nettype none
package rpk_pkg;
	localparam int ACC_W         = 48;
	localparam int QDEPTH_DEF    = 2;
	localparam int EXP_TERMS     = 20;
	localparam int EXP_SQUARINGS = 6;

	typedef enum logic [1:0] {
		REG_KERNEL_MODE = 2'd0,
		REG_RBF_SCALE   = 2'd1,
		REG_POLY_OFFSET = 2'd2,
		REG_POLY_ORDER  = 2'd3
	} reg_idx_t;

	localparam logic MODE_RBF  = 1'b0;
	localparam logic MODE_POLY = 1'b1;

	typedef struct packed {
		logic               kernel_mode;
		logic        [31:0] rbf_scale;
		logic signed [31:0] poly_offset;
		logic        [3:0]  poly_order;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] xx;
		logic signed [ACC_W-1:0] yy;
		logic signed [ACC_W-1:0] xy;
	} sums_t;
endpackage
`default_nettype wire

>>> hdl/rbf_poly_kernel_evaluator_top.sv
// Top level of the RBF / polynomial kernel evaluator: config registers,
// front accumulator, queue and back-end sequencer. Depends on rpk_pkg and all rpk_ modules.
//
// channel  dir  handshake            contents
// s_       in   s_tvalid/s_tready    tdata {y_elem, x_elem}, tlast = last
// m_       out  m_tvalid/m_tready    tdata kernel_value, tuser[0] saturated
// cfg_     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Element pairs are taken at one per cycle; the front stalls only when the queue is full.
// An RBF result takes 20 series terms, each a multiply plus a divide, then six squarings;
// a polynomial result takes one multiply per order step.
// All control state clears on arst_n; there is no clearing pass.
// The output word holds while m_tready is low; the back end then waits in its last state.
`default_nettype none
module rbf_poly_kernel_evaluator_top #(
	parameter int QDEPTH = rpk_pkg::QDEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [15:0] x_elem, [31:16] y_elem
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // [63:0] kernel_value
	output logic [0:0]  m_tuser,   // [0] saturated
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import rpk_pkg::*;

	cfg_t  cfg_q;
	sums_t push_data, head;
	logic  push, full, pop, not_empty, sat;
	logic signed [63:0] value;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_mode <= MODE_RBF;
			cfg_q.rbf_scale   <= 32'd8388608;
			cfg_q.poly_offset <= '0;
			cfg_q.poly_order  <= 4'd2;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KERNEL_MODE: cfg_q.kernel_mode <= cfg_data[0];
				REG_RBF_SCALE:   cfg_q.rbf_scale   <= cfg_data;
				REG_POLY_OFFSET: cfg_q.poly_offset <= cfg_data;
				REG_POLY_ORDER:  cfg_q.poly_order  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	rpk_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.x_elem(s_tdata[15:0]), .y_elem(s_tdata[31:16]), .last(s_tlast),
		.push(push), .push_data(push_data), .q_full(full)
	);

	rpk_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	rpk_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(not_empty), .q_pop(pop),
		.q_head(head), .out_valid(m_tvalid), .out_ready(m_tready),
		.out_value(value), .out_sat(sat)
	);

	assign m_tdata = value;
	assign m_tuser = sat;
endmodule
`default_nettype wire

>>> hdl/rpk_front.sv
// Front end: accepts element pairs and keeps three saturating dot products.
// Depends on rpk_pkg; pushes finished sums into the queue.
`default_nettype none
module rpk_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire signed [15:0] x_elem,
	input  wire signed [15:0] y_elem,
	input  wire               last,
	output logic              push,
	output rpk_pkg::sums_t    push_data,
	input  wire               q_full
);
	import rpk_pkg::*;

	logic signed [ACC_W-1:0] xx_q, yy_q, xy_q;
	logic signed [31:0] pxx, pyy, pxy;
	sums_t nxt;
	logic acc_en;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] acc, input logic signed [31:0] p);
		logic signed [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + {{(ACC_W-31){p[31]}}, p};
		if (s[ACC_W] != s[ACC_W-1])
			sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			sat_add = s[ACC_W-1:0];
	endfunction

	// form products and next sums
	always_comb begin
		pxx = x_elem * x_elem;
		pyy = y_elem * y_elem;
		pxy = x_elem * y_elem;
		nxt.xx = sat_add(xx_q, pxx);
		nxt.yy = sat_add(yy_q, pyy);
		nxt.xy = sat_add(xy_q, pxy);
	end

	assign in_ready  = !q_full;
	assign acc_en    = in_valid && in_ready;
	assign push      = acc_en && last;
	assign push_data = nxt;

	// accumulate, clear after the last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= '0;
			yy_q <= '0;
			xy_q <= '0;
		end else if (acc_en) begin
			if (last) begin
				xx_q <= '0;
				yy_q <= '0;
				xy_q <= '0;
			end else begin
				xx_q <= nxt.xx;
				yy_q <= nxt.yy;
				xy_q <= nxt.xy;
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/rpk_queue.sv
// Short queue of finished dot-product sets between front and back end.
// Depends on rpk_pkg and the assertion macro header.
`default_nettype none
module rpk_queue #(
	parameter int DEPTH = rpk_pkg::QDEPTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  rpk_pkg::sums_t push_data,
	output logic           full,
	input  wire            pop,
	output logic           not_empty,
	output rpk_pkg::sums_t head
);
	import rpk_pkg::*;
	`include "rbf_poly_kernel_evaluator_top_assert.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sums_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`RPK_ASSERT_NEVER(a_push_full, push && full && !pop)
	`RPK_ASSERT_NEVER(a_pop_empty, pop && !not_empty)
	`RPK_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
endmodule
`default_nettype wire

>>> hdl/rpk_mul.sv
// 64x64 unsigned multiplier built from four 32x32 partial products.
// No dependencies; result valid when done pulses.
`default_nettype none
module rpk_mul (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [63:0]  a,
	input  wire  [63:0]  b,
	output logic         done,
	output logic [127:0] p
);
	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [31:0]  op_a, op_b;
	logic [1:0]   sh;
	logic [127:0] pp_ext;

	// select halves for this partial product
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin op_a = a_q[31:0];  op_b = b_q[31:0];  sh = 2'd0; end
			2'd1: begin op_a = a_q[31:0];  op_b = b_q[63:32]; sh = 2'd1; end
			2'd2: begin op_a = a_q[63:32]; op_b = b_q[31:0];  sh = 2'd1; end
			default: begin op_a = a_q[63:32]; op_b = b_q[63:32]; sh = 2'd2; end
		endcase
		case (sh_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		pp_s1 <= op_a * op_b;
		sh_s1 <= sh;
	end

	// step through products, sum them in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q != 3'd0) acc_q <= acc_q + pp_ext;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule
`default_nettype wire

>>> hdl/rpk_div.sv
// Restoring divider of a 64-bit value by a small integer, one bit a cycle.
// No dependencies; quotient valid when done pulses.
`default_nettype none
module rpk_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] dividend,
	input  wire  [4:0]  divisor,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] q_q;
	logic [4:0]  r_q, d_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [5:0]  trial;
	logic        fit;

	assign trial = {r_q, q_q[63]};
	assign fit   = (trial >= {1'b0, d_q});

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[62:0], fit};
			r_q <= fit ? 5'(trial - {1'b0, d_q}) : trial[4:0];
		end
	end

	// count the 64 steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

>>> hdl/rpk_back.sv
// Back end: turns a set of dot products into an RBF or polynomial kernel value.
// Depends on rpk_pkg, rpk_mul and rpk_div; owns the output register.
`default_nettype none
module rpk_back (
	input  wire                clk,
	input  wire                arst_n,
	input  rpk_pkg::cfg_t      cfg,
	input  wire                q_valid,
	output logic               q_pop,
	input  rpk_pkg::sums_t     q_head,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [63:0] out_value,
	output logic               out_sat
);
	import rpk_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_RARG, ST_TMUL, ST_TWAIT, ST_TDIV, ST_SQ, ST_SQW,
		ST_PINIT, ST_PMUL, ST_PWAIT, ST_DONE
	} state_t;

	state_t st_q;
	sums_t  sums_q;
	logic [63:0] term_q, tp_q, s_q, m_q, mag_q, res_q;
	logic [4:0]  n_q;
	logic [3:0]  k_q;
	logic [2:0]  sq_q;
	logic        neg_q, sat_q;
	logic        ov_q;
	logic signed [63:0] ov_val_q;

	logic         mul_start, mul_done, div_start, div_done;
	logic [63:0]  mul_a, mul_b, div_q;
	logic [127:0] mul_p, psum;
	logic signed [63:0] dsq, base;
	logic [63:0]  dclamp, limit, mc, sq_next;

	always_comb begin
		dsq = {{16{sums_q.xx[ACC_W-1]}}, sums_q.xx} + {{16{sums_q.yy[ACC_W-1]}}, sums_q.yy}
			- ({{16{sums_q.xy[ACC_W-1]}}, sums_q.xy} <<< 1);
		dclamp = dsq[63] ? 64'd0 : dsq;
		base = {{16{sums_q.xy[ACC_W-1]}}, sums_q.xy} + {{32{cfg.poly_offset[31]}}, cfg.poly_offset};
		limit = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		psum = mul_p + 128'h80_0000;
		mc = psum[87:24];
		sq_next = mul_p[123:60];
		mul_start = (st_q == ST_RD) || (st_q == ST_TMUL) || (st_q == ST_SQ) || (st_q == ST_PMUL);
		case (st_q)
			ST_RD:   begin mul_a = {32'd0, cfg.rbf_scale}; mul_b = dclamp; end
			ST_SQ:   begin mul_a = s_q; mul_b = s_q; end
			ST_PMUL: begin mul_a = m_q; mul_b = mag_q; end
			default: begin mul_a = term_q; mul_b = tp_q; end
		endcase
		div_start = (st_q == ST_TWAIT) && mul_done;
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;

	rpk_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	rpk_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sq_next),
		.divisor(n_q), .done(div_done), .quot(div_q)
	);

	// sequence one kernel evaluation, hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_valid <= 1'b0;
			out_value <= '0;
			out_sat   <= 1'b0;
			sums_q    <= '0;
			term_q    <= '0;
			tp_q      <= '0;
			s_q       <= '0;
			m_q       <= '0;
			mag_q     <= '0;
			res_q     <= '0;
			n_q       <= '0;
			k_q       <= '0;
			sq_q      <= '0;
			neg_q     <= 1'b0;
			sat_q     <= 1'b0;
			ov_q      <= 1'b0;
			ov_val_q  <= '0;
		end else begin
			if (out_valid && out_ready && st_q != ST_DONE) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						sums_q <= q_head;
						sat_q  <= 1'b0;
						st_q   <= (cfg.kernel_mode == MODE_POLY) ? ST_PINIT : ST_RD;
					end
				end
				ST_RD: st_q <= ST_RARG;
				ST_RARG: begin
					if (mul_done) begin
						if ((|mul_p[127:64]) || (|mul_p[63:53])) begin
							res_q <= '0;
							st_q  <= ST_DONE;
						end else begin
							tp_q   <= {mul_p[57:24], 30'd0};
							term_q <= 64'h1000_0000_0000_0000;
							s_q    <= 64'h1000_0000_0000_0000;
							n_q    <= 5'd1;
							st_q   <= ST_TMUL;
						end
					end
				end
				ST_TMUL: st_q <= ST_TWAIT;
				ST_TWAIT: if (mul_done) st_q <= ST_TDIV;
				ST_TDIV: begin
					if (div_done) begin
						term_q <= div_q;
						s_q    <= n_q[0] ? s_q - div_q : s_q + div_q;
						if (n_q == 5'(EXP_TERMS)) begin
							sq_q <= '0;
							st_q <= ST_SQ;
						end else begin
							n_q  <= n_q + 1'b1;
							st_q <= ST_TMUL;
						end
					end
				end
				ST_SQ: st_q <= ST_SQW;
				ST_SQW: begin
					if (mul_done) begin
						s_q <= sq_next;
						if (sq_q == 3'(EXP_SQUARINGS - 1)) begin
							res_q <= (sq_next + 64'h8_0000_0000) >> 36;
							st_q  <= ST_DONE;
						end else begin
							sq_q <= sq_q + 1'b1;
							st_q <= ST_SQ;
						end
					end
				end
				ST_PINIT: begin
					neg_q <= base[63] && cfg.poly_order[0];
					mag_q <= base[63] ? 64'(-base) : base;
					m_q   <= 64'h100_0000;
					k_q   <= '0;
					if (cfg.poly_order == 4'd0) begin
						res_q <= 64'h100_0000;
						st_q  <= ST_DONE;
					end else begin
						st_q <= ST_PMUL;
					end
				end
				ST_PMUL: st_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (mul_done) begin
						if ((|psum[127:88]) || (mc > limit)) begin
							res_q <= neg_q ? 64'(-limit) : limit;
							sat_q <= 1'b1;
							st_q  <= ST_DONE;
						end else begin
							m_q <= mc;
							k_q <= k_q + 1'b1;
							if ({1'b0, k_q} + 5'd1 == {1'b0, cfg.poly_order}) begin
								res_q <= neg_q ? 64'(-mc) : mc;
								st_q  <= ST_DONE;
							end else begin
								st_q <= ST_PMUL;
							end
						end
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_value <= res_q;
						out_sat   <= sat_q;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			ov_q     <= out_valid && !out_ready;
			ov_val_q <= out_value;
		end
	end

	`include "rbf_poly_kernel_evaluator_top_assert.svh"
	`RPK_ASSERT_NEXT(a_hold_word, out_valid && !out_ready, out_valid && out_value == ov_val_q)
	`RPK_ASSERT_NEVER(a_pop_busy, q_pop && st_q != ST_IDLE)
	`RPK_ASSERT_NEVER(a_stall_track, ov_q && !out_valid)
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for rbf_poly_kernel_evaluator_top: streams element pairs and
// checks every kernel word against a bit-exact predictor of the RBF and polynomial paths
// or a directed value. Depends on rpk_pkg and the RTL of the kernel evaluator.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rpk_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd8_000_000;
	localparam int RAND_ITEMS = 850;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [15:0] x_elem, [31:16] y_elem
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // [63:0] kernel_value
	logic [0:0]  m_tuser;    // [0] saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	typedef struct {
		logic [63:0] kval;
		logic        sat;
	} kernel_word_t;

	typedef struct {
		bit          new_cfg;
		cfg_t        cfg;
		logic [15:0] x;
		logic [15:0] y;
		bit          last;
		bit          typed;
		logic [63:0] kval;
		logic        sat;
	} stim_row_t;

	kernel_word_t kernel_q[$];
	stim_row_t    stim_rows[$];
	cfg_t         cur_cfg;
	logic signed [ACC_W-1:0] acc_xx, acc_yy, acc_xy;
	int           fail_count;
	longint       cycle_count;
	int           burst_left, gap_left;
	int           stall_mode, stall_timer;

	rbf_poly_kernel_evaluator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Add a product into a 48-bit accumulator, clamping at the rails
	function automatic logic signed [ACC_W-1:0] sat_accumulate(
			logic signed [ACC_W-1:0] acc, logic signed [31:0] p);
		logic signed [63:0] v;
		logic signed [63:0] hi_rail;
		logic signed [63:0] lo_rail;
		hi_rail = 64'sh0000_7FFF_FFFF_FFFF;
		lo_rail = -hi_rail - 1;
		v = acc;
		v = v + p;
		if (v > hi_rail) v = hi_rail;
		if (v < lo_rail) v = lo_rail;
		return v[ACC_W-1:0];
	endfunction

	// (a*b) >> 60, truncated to 64 bits
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> 60;
		return p[63:0];
	endfunction

	// exp(-scale*d) by Taylor series of a/64 and six squarings
	function automatic logic [63:0] rbf_kernel();
		logic signed [63:0] d;
		logic [127:0] p;
		logic [63:0] tp, term, s;
		d = acc_xx;
		d = d + acc_yy;
		d = d - acc_xy;
		d = d - acc_xy;
		if (d < 0) d = 0;
		p = {96'd0, cur_cfg.rbf_scale} * {64'd0, d};
		if (p[127:53] != 0) return 64'd0;
		tp = (p[63:0] >> 24) << 30;
		term = 64'd1 << 60;
		s = term;
		for (int n = 1; n <= EXP_TERMS; n++) begin
			term = mul_q60(term, tp) / n;
			if (n % 2) s = s - term;
			else s = s + term;
		end
		for (int n = 0; n < EXP_SQUARINGS; n++) s = mul_q60(s, s);
		return (s + (64'd1 << 35)) >> 36;
	endfunction

	// (xy + offset)^order with per-step Q.24 rounding and clipping
	function automatic kernel_word_t poly_kernel();
		logic signed [63:0] base;
		logic [63:0] mag, lim, m;
		logic [127:0] p;
		logic neg;
		kernel_word_t w;
		base = acc_xy;
		base = base + cur_cfg.poly_offset;
		neg = (base < 0) && cur_cfg.poly_order[0];
		mag = (base < 0) ? -base : base;
		lim = neg ? (64'd1 << 63) : ((64'd1 << 63) - 1);
		m = 64'd1 << 24;
		w.sat = 1'b0;
		for (int k = 0; k < cur_cfg.poly_order; k++) begin
			p = {64'd0, m} * {64'd0, mag} + (128'd1 << 23);
			if (p[127:88] != 0) begin
				m = lim;
				w.sat = 1'b1;
				break;
			end
			m = p[87:24];
			if (m > lim) begin
				m = lim;
				w.sat = 1'b1;
				break;
			end
		end
		w.kval = neg ? -m : m;
		return w;
	endfunction

	// Advance the predictor by one accepted pair; returns 1 when a word is due
	function automatic bit accumulate_pair(logic [15:0] x, logic [15:0] y, bit last,
			output kernel_word_t w);
		logic signed [31:0] xs, ys;
		xs = $signed(x);
		ys = $signed(y);
		acc_xx = sat_accumulate(acc_xx, xs * xs);
		acc_yy = sat_accumulate(acc_yy, ys * ys);
		acc_xy = sat_accumulate(acc_xy, xs * ys);
		w.kval = '0;
		w.sat = 1'b0;
		if (!last) return 1'b0;
		if (cur_cfg.kernel_mode == MODE_POLY) w = poly_kernel();
		else w.kval = rbf_kernel();
		acc_xx = '0;
		acc_yy = '0;
		acc_xy = '0;
		return 1'b1;
	endfunction

	// Send one pair with bursty gaps; record the expected word on acceptance
	task automatic send_pair(logic [15:0] x, logic [15:0] y, bit last, bit typed,
			logic [63:0] kval, logic sat);
		kernel_word_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (accumulate_pair(x, y, last, w)) begin
			if (typed) begin
				w.kval = kval;
				w.sat = sat;
			end
			kernel_q.push_back(w);
		end
	endtask

	// Drain outstanding words, then let the back end settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (kernel_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write all four registers while idle
	task automatic write_config(cfg_t c);
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			reg_idx_t idx;
			idx = reg_idx_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_KERNEL_MODE: cfg_data <= {31'd0, c.kernel_mode};
				REG_RBF_SCALE:   cfg_data <= c.rbf_scale;
				REG_POLY_OFFSET: cfg_data <= c.poly_offset;
				default:         cfg_data <= {28'd0, c.poly_order};
			endcase
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic cfg_t make_cfg(logic mode, logic [31:0] scale, logic [31:0] offset,
			logic [3:0] order);
		cfg_t c;
		c.kernel_mode = mode;
		c.rbf_scale = scale;
		c.poly_offset = offset;
		c.poly_order = order;
		return c;
	endfunction

	task automatic add_row(bit new_cfg, cfg_t c, logic [15:0] x, logic [15:0] y, bit last,
			bit typed, logic [63:0] kval, logic sat);
		stim_row_t r;
		r.new_cfg = new_cfg;
		r.cfg = c;
		r.x = x;
		r.y = y;
		r.last = last;
		r.typed = typed;
		r.kval = kval;
		r.sat = sat;
		stim_rows.push_back(r);
	endtask

	// Receiver: stall pattern switches between always-ready, coin-flip and mostly-stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			stall_timer <= 0;
		end else begin
			if (stall_timer == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_timer <= $urandom_range(16, 200);
			end else begin
				stall_timer <= stall_timer - 1;
			end
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (kernel_q.size() == 0) begin
				$display("%0t: unexpected word kernel_value=%h saturated=%b",
					$realtime, m_tdata, m_tuser[0]);
				fail_count++;
			end else begin
				kernel_word_t w;
				w = kernel_q.pop_front();
				if (m_tdata !== w.kval) begin
					$display("%0t: kernel_value expected %h actual %h",
						$realtime, w.kval, m_tdata);
					fail_count++;
				end
				if (m_tuser[0] !== w.sat) begin
					$display("%0t: saturated expected %b actual %b",
						$realtime, w.sat, m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cfg_t c, reset_cfg;
		int items, vec_len;
		logic [15:0] x, y;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_KERNEL_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_left = 0;
		acc_xx = '0;
		acc_yy = '0;
		acc_xy = '0;
		reset_cfg = make_cfg(MODE_RBF, 32'd8388608, 32'd0, 4'd2);
		cur_cfg = reset_cfg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: reset settings, extremes, order zero, clipping both signs
		add_row(0, reset_cfg, 16'h1000, 16'h1000, 1, 1, 64'd16777216, 0);
		add_row(0, reset_cfg, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
		add_row(0, reset_cfg, 16'h7FFF, 16'h8000, 1, 1, 64'd0, 0);
		add_row(0, reset_cfg, 16'h1000, 16'h0000, 1, 0, 0, 0);
		add_row(0, reset_cfg, 16'h0001, 16'hFFFF, 1, 0, 0, 0);
		c = make_cfg(MODE_RBF, 32'hFFFF_FFFF, 32'd0, 4'd2);
		add_row(1, c, 16'h0001, 16'h0000, 1, 0, 0, 0);
		add_row(0, c, 16'h0040, 16'h0000, 1, 0, 0, 0);
		c = make_cfg(MODE_RBF, 32'd0, 32'd0, 4'd2);
		add_row(1, c, 16'h8000, 16'h7FFF, 1, 1, 64'd16777216, 0);
		c = make_cfg(MODE_POLY, 32'd0, 32'd0, 4'd0);
		add_row(1, c, 16'h0005, 16'h0007, 1, 1, 64'd16777216, 0);
		c = make_cfg(MODE_POLY, 32'd0, 32'h7FFF_FFFF, 4'd15);
		add_row(1, c, 16'h7FFF, 16'h7FFF, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1);
		c = make_cfg(MODE_POLY, 32'd0, 32'h8000_0000, 4'd15);
		add_row(1, c, 16'h8000, 16'h7FFF, 1, 1, 64'h8000_0000_0000_0000, 1);
		add_row(0, c, 16'h0000, 16'h0000, 1, 0, 0, 0);
		c = make_cfg(MODE_POLY, 32'd0, 32'h8000_0000, 4'd14);
		add_row(1, c, 16'h8000, 16'h7FFF, 1, 0, 0, 0);
		c = make_cfg(MODE_POLY, 32'd0, 32'h0100_0000, 4'd2);
		add_row(1, c, 16'h1000, 16'h1000, 0, 0, 0, 0);
		add_row(0, c, 16'h2000, 16'hF000, 1, 0, 0, 0);
		add_row(0, c, 16'hFFFF, 16'h0001, 1, 0, 0, 0);
		c = make_cfg(MODE_POLY, 32'd0, 32'hFF80_0000, 4'd3);
		add_row(1, c, 16'h0800, 16'h0800, 1, 0, 0, 0);
		add_row(0, c, 16'h0000, 16'h0000, 1, 0, 0, 0);
		foreach (stim_rows[i]) begin
			if (stim_rows[i].new_cfg) write_config(stim_rows[i].cfg);
			send_pair(stim_rows[i].x, stim_rows[i].y, stim_rows[i].last,
				stim_rows[i].typed, stim_rows[i].kval, stim_rows[i].sat);
		end

		// Random vectors under changing settings
		items = 0;
		while (items < RAND_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				c.kernel_mode = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0:       c.rbf_scale = 32'd0;
					1:       c.rbf_scale = 32'hFFFF_FFFF;
					2:       c.rbf_scale = $urandom;
					default: c.rbf_scale = $urandom_range(0, 32'h0400_0000);
				endcase
				case ($urandom_range(0, 3))
					0:       c.poly_offset = 32'h8000_0000;
					1:       c.poly_offset = 32'h7FFF_FFFF;
					2:       c.poly_offset = $urandom;
					default: c.poly_offset = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
				endcase
				c.poly_order = 4'($urandom_range(0, 15));
				write_config(c);
			end
			vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int i = 0; i < vec_len; i++) begin
				x = 16'($urandom);
				if ($urandom_range(0, 2) == 0) y = 16'($urandom);
				else y = 16'(x + $urandom_range(0, 64) - 32);
				if ($urandom_range(0, 1)) begin
					x = 16'($signed(x) >>> $urandom_range(0, 12));
					y = 16'($signed(y) >>> $urandom_range(0, 12));
				end
				send_pair(x, y, i == vec_len - 1, 0, 0, 0);
				items++;
			end
		end

		// Drain and report
		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && kernel_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
